### rtl/sblt_pkg.sv
// sblt_pkg: shared types and constants of the scoped borrow lock table
// operation and error codes, default sizes, controller command and status
// no dependencies
`default_nettype none

package sblt_pkg;

	localparam int unsigned ENTRIES_DEF    = 256;
	localparam int unsigned SCOPE_BITS_DEF = 8;
	localparam int unsigned COUNT_BITS_DEF = 8;

	localparam int unsigned OP_W     = 4;
	localparam int unsigned ERR_W    = 4;
	localparam int unsigned VAR_ID_W = 8;
	localparam int unsigned VAR_ID_N = 1 << VAR_ID_W;

	typedef enum logic [OP_W-1:0] {
		OP_DECLARE  = 4'd0,
		OP_USE      = 4'd1,
		OP_ASSIGN   = 4'd2,
		OP_MOVE     = 4'd3,
		OP_BORROW_S = 4'd4,
		OP_BORROW_M = 4'd5,
		OP_RELEASE  = 4'd6,
		OP_EXIT     = 4'd7,
		OP_ENTER    = 4'd8,
		OP_QUERY    = 4'd9
	} sblt_op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE             = 4'd0,
		ERR_REDECL           = 4'd1,
		ERR_USE_MOVED        = 4'd2,
		ERR_ASSIGN_UNDECL    = 4'd3,
		ERR_ASSIGN_IMMUT     = 4'd4,
		ERR_ASSIGN_SHARED    = 4'd5,
		ERR_ASSIGN_MUT       = 4'd6,
		ERR_BORROW_MOVED     = 4'd7,
		ERR_SHARED_WHILE_MUT = 4'd8,
		ERR_MUT_OF_IMMUT     = 4'd9,
		ERR_MUT_WHILE_SHARED = 4'd10,
		ERR_MUT_TWICE        = 4'd11
	} sblt_err_t;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;   // write a zero entry at the sweep counter
		logic sweep_rd; // read the entry at the sweep counter for scope exit
		logic look_rd;  // capture the request and read its entry
		logic fix_rd;   // read the captured entry again
		logic exec;     // read-modify-write of the entry, load the result
	} sblt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ctr_last; // sweep counter at the last entry
		logic req_exit; // offered request is a scope exit
	} sblt_sts_t;

endpackage

`default_nettype wire

### rtl/sblt_in_if.sv
// sblt_in_if: request channel of the scoped borrow lock table
// valid/ready handshake with the operation payload; uses sblt_pkg widths
`default_nettype none

interface sblt_in_if;
	logic                             valid;
	logic                             ready;
	logic [sblt_pkg::OP_W-1:0]        op;
	logic [sblt_pkg::VAR_ID_W-1:0]    var_id;
	logic                             new_mutable;
	logic                             release_mutable;

	modport source (output valid, output op, output var_id, output new_mutable,
		output release_mutable, input ready);
	modport sink (input valid, input op, input var_id, input new_mutable,
		input release_mutable, output ready);
endinterface

`default_nettype wire

### rtl/sblt_out_if.sv
// sblt_out_if: result channel of the scoped borrow lock table
// valid/ready handshake with the result payload; uses sblt_pkg widths
`default_nettype none

interface sblt_out_if;
	logic                       valid;
	logic                       ready;
	logic                       ok;
	logic [sblt_pkg::ERR_W-1:0] error_code;
	logic                       found;
	logic                       var_mutable;

	modport source (output valid, output ok, output error_code, output found,
		output var_mutable, input ready);
	modport sink (input valid, input ok, input error_code, input found,
		input var_mutable, output ready);
endinterface

`default_nettype wire

### rtl/sblt_ctrl.sv
// sblt_ctrl: sequencer of the scoped borrow lock table
// clearing pass, lookup, scope-exit sweep and result handoff; uses sblt_pkg
`default_nettype none

module sblt_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire sblt_pkg::sblt_sts_t sts,
	output sblt_pkg::sblt_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SWEEP,
		S_DRAIN,
		S_READ,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_ready && in_valid;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clr_wr   = 1'b1;
			S_IDLE:  cmd.look_rd  = in_valid;
			S_SWEEP: cmd.sweep_rd = 1'b1;
			S_DRAIN: ;
			S_READ:  cmd.fix_rd   = 1'b1;
			S_EXEC:  cmd.exec     = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (sts.ctr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= sts.req_exit ? S_SWEEP : S_EXEC;
				end
				S_SWEEP: begin
					if (sts.ctr_last) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_READ;
				S_READ:  state_q <= S_EXEC;
				S_EXEC: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_lookup_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !sts.req_exit |=> state_q == S_EXEC)
		else $error("lookup not followed by execute");

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("executed operation left no result");
`endif

endmodule

`default_nettype wire

### rtl/sblt_dp.sv
// sblt_dp: datapath of the scoped borrow lock table
// entry memory, index table, sweep pipe, operation rules, result register
// uses sblt_pkg; driven by sblt_ctrl
`default_nettype none

module sblt_dp #(
	parameter int unsigned ENTRIES    = sblt_pkg::ENTRIES_DEF,
	parameter int unsigned SCOPE_BITS = sblt_pkg::SCOPE_BITS_DEF,
	parameter int unsigned COUNT_BITS = sblt_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sblt_pkg::sblt_cmd_t           cmd,
	output sblt_pkg::sblt_sts_t                sts,
	input  wire logic [sblt_pkg::OP_W-1:0]     op,
	input  wire logic [sblt_pkg::VAR_ID_W-1:0] var_id,
	input  wire logic                          new_mutable,
	input  wire logic                          release_mutable,
	output logic                               ok,
	output logic [sblt_pkg::ERR_W-1:0]         error_code,
	output logic                               found,
	output logic                               var_mutable
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef struct packed {
		logic                  valid;
		logic                  mutable;
		logic                  moved;
		logic [SCOPE_BITS-1:0] scope;
		logic [COUNT_BITS-1:0] count;
		logic                  mut;
	} entry_t;

	// var_id to entry index, folded at elaboration
	logic [IDX_W-1:0] mod_tab [sblt_pkg::VAR_ID_N];
	for (genvar g = 0; g < sblt_pkg::VAR_ID_N; g++) begin : g_mod
		localparam int unsigned REM = g % ENTRIES;
		assign mod_tab[g] = IDX_W'(REM);
	end

	entry_t                mem_q [ENTRIES];
	entry_t                rd_q;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	entry_t                wr_data;

	sblt_pkg::sblt_op_t    op_q;
	logic [IDX_W-1:0]      ix_q;
	logic                  nm_q;
	logic                  rm_q;
	logic [SCOPE_BITS-1:0] scope_q;
	logic [IDX_W-1:0]      ctr_q;
	logic                  swp_s1;
	logic [IDX_W-1:0]      swp_addr_s1;
	logic                  swp_hit;

	entry_t                nxt;
	logic                  nxt_we;
	logic                  nxt_ok;
	sblt_pkg::sblt_err_t   nxt_err;
	logic                  hit;

	logic                  ok_q;
	logic [sblt_pkg::ERR_W-1:0] err_q;
	logic                  found_q;
	logic                  vmut_q;

	assign sts.ctr_last = (ctr_q == IDX_W'(ENTRIES - 1));
	assign sts.req_exit = (sblt_pkg::sblt_op_t'(op) == sblt_pkg::OP_EXIT);

	// read port
	assign rd_en = cmd.look_rd || cmd.fix_rd || cmd.sweep_rd;
	always_comb begin
		priority if (cmd.look_rd) rd_addr = mod_tab[var_id];
		else if (cmd.sweep_rd)    rd_addr = ctr_q;
		else                      rd_addr = ix_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	// write port
	assign swp_hit = swp_s1 && rd_q.valid && (rd_q.scope == scope_q);
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ix_q;
		wr_data = '0;
		priority if (cmd.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = ctr_q;
		end else if (swp_hit) begin
			wr_en   = 1'b1;
			wr_addr = swp_addr_s1;
		end else if (cmd.exec) begin
			wr_en   = nxt_we;
			wr_data = nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	// sweep counter and pipe, request capture, scope level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q   <= '0;
			swp_s1  <= 1'b0;
			scope_q <= '0;
		end else begin
			if (cmd.clr_wr || cmd.sweep_rd) begin
				ctr_q <= sts.ctr_last ? '0 : ctr_q + 1'b1;
			end
			swp_s1 <= cmd.sweep_rd;
			if (cmd.exec) begin
				if (op_q == sblt_pkg::OP_EXIT && scope_q != '0) begin
					scope_q <= scope_q - 1'b1;
				end else if (op_q == sblt_pkg::OP_ENTER && scope_q != '1) begin
					scope_q <= scope_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_rd) swp_addr_s1 <= ctr_q;
		if (cmd.look_rd) begin
			op_q <= sblt_pkg::sblt_op_t'(op);
			ix_q <= mod_tab[var_id];
			nm_q <= new_mutable;
			rm_q <= release_mutable;
		end
	end

	// operation rules on the entry just read
	assign hit = rd_q.valid;
	always_comb begin
		nxt     = rd_q;
		nxt_we  = 1'b0;
		nxt_ok  = 1'b1;
		nxt_err = sblt_pkg::ERR_NONE;
		case (op_q)
			sblt_pkg::OP_DECLARE: begin
				if (hit && rd_q.scope == scope_q) begin
					nxt_err = sblt_pkg::ERR_REDECL;
				end else begin
					nxt         = '0;
					nxt.valid   = 1'b1;
					nxt.mutable = nm_q;
					nxt.scope   = scope_q;
					nxt_we      = 1'b1;
				end
			end
			sblt_pkg::OP_USE: begin
				if (hit && rd_q.moved) nxt_err = sblt_pkg::ERR_USE_MOVED;
			end
			sblt_pkg::OP_ASSIGN: begin
				priority if (!hit)        nxt_err = sblt_pkg::ERR_ASSIGN_UNDECL;
				else if (!rd_q.mutable)   nxt_err = sblt_pkg::ERR_ASSIGN_IMMUT;
				else if (rd_q.count != '0) nxt_err = sblt_pkg::ERR_ASSIGN_SHARED;
				else if (rd_q.mut)        nxt_err = sblt_pkg::ERR_ASSIGN_MUT;
				else                      ;
			end
			sblt_pkg::OP_MOVE: begin
				if (hit) begin
					nxt.moved = 1'b1;
					nxt_we    = 1'b1;
				end
			end
			sblt_pkg::OP_BORROW_S: begin
				if (hit) begin
					priority if (rd_q.moved) nxt_err = sblt_pkg::ERR_BORROW_MOVED;
					else if (rd_q.mut)       nxt_err = sblt_pkg::ERR_SHARED_WHILE_MUT;
					else if (rd_q.count != '1) begin
						nxt.count = rd_q.count + 1'b1;
						nxt_we    = 1'b1;
					end else                 ;
				end
			end
			sblt_pkg::OP_BORROW_M: begin
				if (hit) begin
					priority if (rd_q.moved)    nxt_err = sblt_pkg::ERR_BORROW_MOVED;
					else if (!rd_q.mutable)     nxt_err = sblt_pkg::ERR_MUT_OF_IMMUT;
					else if (rd_q.count != '0)  nxt_err = sblt_pkg::ERR_MUT_WHILE_SHARED;
					else if (rd_q.mut)          nxt_err = sblt_pkg::ERR_MUT_TWICE;
					else begin
						nxt.mut = 1'b1;
						nxt_we  = 1'b1;
					end
				end
			end
			sblt_pkg::OP_RELEASE: begin
				if (hit) begin
					nxt_we = 1'b1;
					priority if (rm_q)         nxt.mut   = 1'b0;
					else if (rd_q.count != '0) nxt.count = rd_q.count - 1'b1;
					else                       ;
				end
			end
			sblt_pkg::OP_EXIT, sblt_pkg::OP_ENTER, sblt_pkg::OP_QUERY: ;
			default: nxt_ok = 1'b0;
		endcase
		if (nxt_err != sblt_pkg::ERR_NONE) nxt_ok = 1'b0;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_q    <= nxt_ok;
			err_q   <= nxt_err;
			found_q <= nxt.valid;
			vmut_q  <= nxt.valid && nxt.mutable;
		end
	end

	assign ok          = ok_q;
	assign error_code  = err_q;
	assign found       = found_q;
	assign var_mutable = vmut_q;

`ifndef NO_ASSERTIONS
	a_sweep_excl: assert property (@(posedge clk) disable iff (!arst_n)
		swp_s1 |-> !cmd.exec && !cmd.clr_wr && !cmd.look_rd)
		else $error("sweep write overlaps another table access");

	a_exit_scope_down: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && op_q == sblt_pkg::OP_EXIT && scope_q != '0
		|=> scope_q == $past(scope_q) - 1'b1)
		else $error("scope exit did not lower the scope level");
`endif

endmodule

`default_nettype wire

### rtl/scoped_borrow_lock_table.sv
// scoped_borrow_lock_table: top level, controller plus datapath
// depends on sblt_pkg, sblt_in_if, sblt_out_if, sblt_ctrl, sblt_dp
//
// Borrow-tracking table with one entry per variable id (var_id modulo ENTRIES),
// each entry holding valid, mutable, moved, scope level, a saturating shared
// borrow count and a mutable borrow flag. After reset the block runs a clearing
// pass (one entry a cycle through the table's write port) and takes no request
// until it is done. In an ordinary operation the request beat is taken and the
// entry read through the registered read port, then the entry is updated in a
// read-modify-write and the result beat loaded into the output register. Exit
// scope walks the table one entry a cycle through that same read and write port
// pair, clearing entries of the current level, then lowers a nonzero scope level
// and loads its result beat. A new request is taken while a finished result still
// waits on the result channel; its update waits until the output register is
// free. Every request gives exactly one result beat.
`default_nettype none

module scoped_borrow_lock_table #(
	parameter int unsigned ENTRIES    = sblt_pkg::ENTRIES_DEF,
	parameter int unsigned SCOPE_BITS = sblt_pkg::SCOPE_BITS_DEF,
	parameter int unsigned COUNT_BITS = sblt_pkg::COUNT_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	sblt_in_if.sink     req,
	sblt_out_if.source  rsp
);

	// command and status between sequencer and datapath
	sblt_pkg::sblt_cmd_t cmd;
	sblt_pkg::sblt_sts_t sts;

	// sequencer: clearing pass, lookup, sweep, result handoff
	sblt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: entry memory, rules, scope level and result register
	sblt_dp #(
		.ENTRIES    (ENTRIES),
		.SCOPE_BITS (SCOPE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.op              (req.op),
		.var_id          (req.var_id),
		.new_mutable     (req.new_mutable),
		.release_mutable (req.release_mutable),
		.ok              (rsp.ok),
		.error_code      (rsp.error_code),
		.found           (rsp.found),
		.var_mutable     (rsp.var_mutable)
	);

endmodule

`default_nettype wire

### tb/testbench.sv
// testbench for scoped_borrow_lock_table: a predictor of the borrow table checks every result beat
// depends on sblt_pkg, sblt_in_if, sblt_out_if and the rtl of the block
import sblt_pkg::*;

typedef struct packed {
	logic              ok;
	logic [ERR_W-1:0]  err;
	logic              found;
	logic              mut;
} verdict_t;

// mirror of the borrow table plus the queue of verdicts still owed by the block
class borrow_ledger;
	bit                             tracked     [ENTRIES_DEF];
	bit                             mutable     [ENTRIES_DEF];
	bit                             moved       [ENTRIES_DEF];
	logic [SCOPE_BITS_DEF-1:0]      level       [ENTRIES_DEF];
	logic [COUNT_BITS_DEF-1:0]      readers     [ENTRIES_DEF];
	bit                             writer_held [ENTRIES_DEF];
	logic [SCOPE_BITS_DEF-1:0]      depth;
	verdict_t                       owed[$];
	int unsigned                    faults;

	function new();
		for (int k = 0; k < ENTRIES_DEF; k++) begin
			tracked[k] = 0;
			mutable[k] = 0;
			moved[k] = 0;
			level[k] = '0;
			readers[k] = '0;
			writer_held[k] = 0;
		end
		depth = '0;
		faults = 0;
	endfunction

	function int unsigned pending();
		return owed.size();
	endfunction

	function int unsigned total_faults();
		return faults + owed.size();
	endfunction

	// apply one accepted request beat to the mirror and queue its verdict
	function void note_request(logic [OP_W-1:0] code, logic [VAR_ID_W-1:0] id, logic nm,
		logic rm);
		int unsigned ix;
		verdict_t v;
		ix = id % ENTRIES_DEF;
		v.ok = 1'b1;
		v.err = ERR_NONE;
		case (code)
			OP_DECLARE: begin
				if (tracked[ix] && level[ix] == depth) begin
					v.err = ERR_REDECL;
				end else begin
					tracked[ix] = 1;
					mutable[ix] = nm;
					moved[ix] = 0;
					level[ix] = depth;
					readers[ix] = '0;
					writer_held[ix] = 0;
				end
			end
			OP_USE: begin
				if (tracked[ix] && moved[ix])
					v.err = ERR_USE_MOVED;
			end
			OP_ASSIGN: begin
				if (!tracked[ix])
					v.err = ERR_ASSIGN_UNDECL;
				else if (!mutable[ix])
					v.err = ERR_ASSIGN_IMMUT;
				else if (readers[ix] != '0)
					v.err = ERR_ASSIGN_SHARED;
				else if (writer_held[ix])
					v.err = ERR_ASSIGN_MUT;
			end
			OP_MOVE: begin
				if (tracked[ix])
					moved[ix] = 1;
			end
			OP_BORROW_S: begin
				if (tracked[ix]) begin
					if (moved[ix])
						v.err = ERR_BORROW_MOVED;
					else if (writer_held[ix])
						v.err = ERR_SHARED_WHILE_MUT;
					else if (readers[ix] != '1)
						readers[ix] = readers[ix] + 1'b1;
				end
			end
			OP_BORROW_M: begin
				if (tracked[ix]) begin
					if (moved[ix])
						v.err = ERR_BORROW_MOVED;
					else if (!mutable[ix])
						v.err = ERR_MUT_OF_IMMUT;
					else if (readers[ix] != '0)
						v.err = ERR_MUT_WHILE_SHARED;
					else if (writer_held[ix])
						v.err = ERR_MUT_TWICE;
					else
						writer_held[ix] = 1;
				end
			end
			OP_RELEASE: begin
				if (tracked[ix]) begin
					if (rm)
						writer_held[ix] = 0;
					else if (readers[ix] != '0)
						readers[ix] = readers[ix] - 1'b1;
				end
			end
			OP_EXIT: begin
				for (int k = 0; k < ENTRIES_DEF; k++) begin
					if (tracked[k] && level[k] == depth) begin
						tracked[k] = 0;
						mutable[k] = 0;
						moved[k] = 0;
						level[k] = '0;
						readers[k] = '0;
						writer_held[k] = 0;
					end
				end
				if (depth != '0)
					depth = depth - 1'b1;
			end
			OP_ENTER: begin
				if (depth != '1)
					depth = depth + 1'b1;
			end
			OP_QUERY: begin
			end
			default: begin
				v.ok = 1'b0;
			end
		endcase
		if (v.err != ERR_NONE)
			v.ok = 1'b0;
		v.found = tracked[ix];
		v.mut = tracked[ix] && mutable[ix];
		owed.insert(owed.size(), v);
	endfunction

	// compare one accepted result beat with the oldest owed verdict
	function void check_result(verdict_t got);
		verdict_t want;
		if (owed.size() == 0) begin
			if (faults < 10)
				$display("[%0t] result beat with nothing owed: ok=%0b err=%0d found=%0b mut=%0b",
					$realtime, got.ok, got.err, got.found, got.mut);
			faults++;
		end else begin
			want = owed.pop_front();
			if (got.ok !== want.ok || got.err !== want.err || got.found !== want.found
				|| got.mut !== want.mut) begin
				if (faults < 10) begin
					$display("[%0t] mismatch: expected ok=%0b err=%0d found=%0b mut=%0b",
						$realtime, want.ok, want.err, want.found, want.mut);
					$display("[%0t] mismatch: got      ok=%0b err=%0d found=%0b mut=%0b",
						$realtime, got.ok, got.err, got.found, got.mut);
				end
				faults++;
			end
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no beat on either side before the run is declared hung;
	// covers the clearing pass, a full scope-exit sweep and the longest stalls
	localparam int unsigned QUIET_LIMIT = 10 * ENTRIES_DEF;
	localparam logic [OP_W-1:0] ILLEGAL_OP = '1;

	logic clk = 1'b0;
	logic arst_n;

	sblt_in_if  req_ch ();
	sblt_out_if rsp_ch ();

	scoped_borrow_lock_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	borrow_ledger ledger;
	int unsigned  quiet_cycles = 0;
	int           send_calm = 0;
	int           recv_calm = 0;
	int           recv_stall = 0;

	always #10 clk = ~clk;

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// result side back-pressure, with calm stretches where ready stays high
	always @(negedge clk) begin
		if (recv_stall > 0) begin
			rsp_ch.ready <= 1'b0;
			recv_stall--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (recv_calm > 0) begin
				recv_calm--;
			end else begin
				recv_stall = pick_gap();
				if ($urandom_range(99) == 0)
					recv_calm = $urandom_range(80, 20);
			end
		end
	end

	// beats are sampled at the rising edge; the request beat is noted before
	// the result beat, although a result never belongs to a beat of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				ledger.note_request(req_ch.op, req_ch.var_id, req_ch.new_mutable,
					req_ch.release_mutable);
				quiet_cycles = 0;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				ledger.check_result({rsp_ch.ok, rsp_ch.error_code, rsp_ch.found,
					rsp_ch.var_mutable});
				quiet_cycles = 0;
			end
			if (quiet_cycles < QUIET_LIMIT)
				quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// drive one request beat; entered and left at a falling edge, valid left high
	task automatic put_beat(input logic [OP_W-1:0] code, input logic [VAR_ID_W-1:0] id,
		input logic nm, input logic rm);
		int gap;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			gap = pick_gap();
			if ($urandom_range(49) == 0)
				send_calm = $urandom_range(60, 20);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= code;
		req_ch.var_id <= id;
		req_ch.new_mutable <= nm;
		req_ch.release_mutable <= rm;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	// hold the request side until every owed result beat has come back
	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (ledger.pending() != 0);
	endtask

	// edge cases of every operation, starting from the empty table at scope zero
	task automatic run_directed();
		put_beat(OP_QUERY, 8'h00, 1'b0, 1'b0);      // untracked lookup
		put_beat(OP_ASSIGN, 8'hFF, 1'b1, 1'b1);     // assign to an undeclared variable
		put_beat(OP_BORROW_M, 8'hFF, 1'b0, 1'b0);   // untracked borrow is let through
		put_beat(OP_RELEASE, 8'hFF, 1'b0, 1'b1);    // untracked release too
		put_beat(OP_DECLARE, 8'h00, 1'b0, 1'b0);    // immutable at scope zero
		put_beat(OP_DECLARE, 8'h00, 1'b1, 1'b0);    // redeclared at the same level
		put_beat(OP_ASSIGN, 8'h00, 1'b0, 1'b0);     // assign to immutable
		put_beat(OP_BORROW_M, 8'h00, 1'b0, 1'b0);   // mutable borrow of immutable
		put_beat(OP_DECLARE, 8'hFF, 1'b1, 1'b1);
		put_beat(OP_BORROW_S, 8'hFF, 1'b0, 1'b0);
		put_beat(OP_ASSIGN, 8'hFF, 1'b0, 1'b0);     // assign while shared
		put_beat(OP_BORROW_M, 8'hFF, 1'b0, 1'b0);   // mutable while shared
		put_beat(OP_RELEASE, 8'hFF, 1'b1, 1'b0);
		put_beat(OP_RELEASE, 8'hFF, 1'b0, 1'b0);    // shared release drops the count to zero
		put_beat(OP_BORROW_M, 8'hFF, 1'b0, 1'b0);
		put_beat(OP_BORROW_S, 8'hFF, 1'b0, 1'b0);   // shared while mutably held
		put_beat(OP_BORROW_M, 8'hFF, 1'b0, 1'b0);   // second mutable borrow
		put_beat(OP_ASSIGN, 8'hFF, 1'b0, 1'b0);     // assign while mutably held
		put_beat(OP_RELEASE, 8'hFF, 1'b0, 1'b1);
		put_beat(OP_ENTER, 8'h5A, 1'b0, 1'b0);
		put_beat(OP_DECLARE, 8'h00, 1'b1, 1'b0);    // inner declare overwrites the outer one
		put_beat(OP_MOVE, 8'h00, 1'b0, 1'b0);
		put_beat(OP_USE, 8'h00, 1'b0, 1'b0);        // use after move
		put_beat(OP_BORROW_S, 8'h00, 1'b0, 1'b0);   // borrow after move
		put_beat(OP_EXIT, 8'hA5, 1'b1, 1'b1);
		put_beat(OP_EXIT, 8'h00, 1'b0, 1'b0);       // exit at the outermost level
		put_beat(ILLEGAL_OP, 8'hFF, 1'b1, 1'b1);
	endtask

	function automatic logic [OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 14) return OP_DECLARE;
		if (r < 23) return OP_USE;
		if (r < 33) return OP_ASSIGN;
		if (r < 38) return OP_MOVE;
		if (r < 53) return OP_BORROW_S;
		if (r < 64) return OP_BORROW_M;
		if (r < 79) return OP_RELEASE;
		if (r < 85) return OP_EXIT;
		if (r < 92) return OP_ENTER;
		if (r < 97) return OP_QUERY;
		return OP_W'($urandom_range((1 << OP_W) - 1, int'(OP_QUERY) + 1));
	endfunction

	// episodes on a small pool of ids so declare, borrow and release chains build up
	task automatic run_mixed(input int count);
		logic [VAR_ID_W-1:0] pool [6];
		logic [VAR_ID_W-1:0] id;
		int left = 0;
		for (int n = 0; n < count; n++) begin
			if (left == 0) begin
				foreach (pool[k])
					pool[k] = VAR_ID_W'($urandom_range(VAR_ID_N - 1));
				left = $urandom_range(40, 15);
			end
			left--;
			id = pool[$urandom_range(5)];
			if ($urandom_range(19) == 0)
				id = VAR_ID_W'($urandom_range(VAR_ID_N - 1));
			put_beat(pick_op(), id, $urandom_range(9) < 7, 1'($urandom_range(1)));
		end
	endtask

	// drive the scope level and one shared count into saturation, interleaved
	task automatic run_stress();
		logic [VAR_ID_W-1:0] hot;
		int enters = 0;
		int shares = 0;
		int r;
		hot = VAR_ID_W'($urandom_range(VAR_ID_N - 1));
		// a fresh level holds no entries, so the declare always lands
		put_beat(OP_ENTER, VAR_ID_W'($urandom_range(VAR_ID_N - 1)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
		put_beat(OP_DECLARE, hot, 1'($urandom_range(1)), 1'($urandom_range(1)));
		while (enters < 258 || shares < 258) begin
			r = $urandom_range(19);
			if (r < 2) begin
				put_beat(r == 0 ? OP_USE : OP_QUERY, hot, 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end else if ((r < 11 && enters < 258) || shares >= 258) begin
				put_beat(OP_ENTER, VAR_ID_W'($urandom_range(VAR_ID_N - 1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
				enters++;
			end else begin
				put_beat(OP_BORROW_S, hot, 1'($urandom_range(1)), 1'($urandom_range(1)));
				shares++;
			end
		end
		// back off the full count and poke at the deepest level
		put_beat(OP_RELEASE, hot, 1'b0, 1'b0);
		put_beat(OP_RELEASE, hot, 1'b1, 1'b0);
		put_beat(OP_BORROW_M, hot, 1'b0, 1'b0);
		put_beat(OP_ASSIGN, hot, 1'b0, 1'b0);
		put_beat(OP_ENTER, 8'h00, 1'b0, 1'b0);
		put_beat(OP_DECLARE, 8'h3C, 1'b1, 1'b0);
		put_beat(OP_EXIT, 8'h3C, 1'b0, 1'b0);
		put_beat(OP_EXIT, 8'hC3, 1'b1, 1'b1);
	endtask

	initial begin
		ledger = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_QUERY;
		req_ch.var_id = '0;
		req_ch.new_mutable = 1'b0;
		req_ch.release_mutable = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		hold_until_drained();
		run_mixed(120);
		hold_until_drained();
		run_stress();
		run_mixed(30);

		// let the last beats come home, then give a full sweep of slack
		req_ch.valid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (2 * ENTRIES_DEF) @(posedge clk);

		if (ledger.total_faults() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### files.f
rtl/sblt_pkg.sv
rtl/sblt_in_if.sv
rtl/sblt_out_if.sv
rtl/sblt_ctrl.sv
rtl/sblt_dp.sv
rtl/scoped_borrow_lock_table.sv
tb/testbench.sv
